[hw/rtl/rrts_pkg.sv]
// Package for the round-robin task scheduler: op codes, slot states, payload structs.
// No dependencies.
package rrts_pkg;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_KILL     = 3'd2,
        OP_SLEEP    = 3'd3,
        OP_EXIT     = 3'd4,
        OP_RESET    = 3'd5
    } t_op;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_DEAD     = 3'd3;
    localparam logic [2:0] ST_TOFREE   = 3'd4;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_REFUSED = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  target_pid;
        logic [15:0] stack_pages;
        logic [31:0] sleep_seconds;
        logic        save_old;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  new_pid;
        logic [3:0]  active_pid;
        logic        switched;
        logic [4:0]  live_count;
        logic [15:0] active_stack_pages;
    } t_out;

endpackage

[hw/rtl/round_robin_task_state_scheduler_core.sv]
// Top level of the round-robin task scheduler: slot table plus a sequencer that
// walks the slots one per cycle with a single compare unit. Depends on rrts_pkg.
//
//  channel | signals                   | direction | transfer
//  input   | i_start, i_in, o_busy     | in        | i_start & !o_busy
//  result  | o_valid, o_out            | out       | o_valid (one cycle, no stall)
//
// Steps: create scans the slots for a free one, then gives the result; a schedule
// pass runs a wake/free sweep, a round-robin search and a result cycle; kill and
// sleep first run a target check; other refused ops go straight to the result.
// The slot sweeps over the one compare unit set how long each op takes.
// Reset: slot 0 running, all other slots dead, table size and live count one.
// Results cannot be stalled; o_busy is high from transfer until the result cycle.
module round_robin_task_state_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rrts_pkg::t_in   i_in,
    output logic            o_busy,
    output logic            o_valid,
    output rrts_pkg::t_out  o_out
);
    import rrts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CSCAN, S_SWEEP, S_SEARCH, S_FINISH, S_DONE
    } t_fsm;

    t_fsm               r_fsm;
    logic [2:0]         r_state [MAX_TASKS];
    logic [31:0]        r_wake  [MAX_TASKS];
    logic [15:0]        r_pages [MAX_TASKS];
    logic [CW-1:0]      r_size;
    logic [IW-1:0]      r_run;
    logic [CW-1:0]      r_count;
    t_in                r_in;
    logic [CW-1:0]      r_idx;
    logic [IW-1:0]      r_cand;
    logic [IW-1:0]      r_chosen;
    logic               r_found;
    logic               r_demote;
    logic [1:0]         r_status;
    logic [IW-1:0]      r_newpid;
    logic               r_sw;

    // shared sweep unit: state of the slot under the pointer and a wake compare
    logic [IW-1:0] w_ptr;
    logic [2:0]    w_st;
    logic          w_wake;
    logic [IW-1:0] w_next;
    logic [CW-1:0] w_tgt;
    logic          w_tgt_bad;
    logic [32:0]   w_sum;

    assign w_ptr  = r_idx[IW-1:0];
    assign w_st   = r_state[w_ptr];
    assign w_wake = (r_in.now_seconds >= r_wake[w_ptr]);
    assign w_next = (CW'(r_cand) + CW'(1) >= r_size) ? '0 : r_cand + 1'b1;
    assign w_tgt  = CW'(r_in.target_pid);
    assign w_tgt_bad = (r_in.target_pid == 4'd0) || (w_tgt >= r_size)
                    || (32'(r_in.target_pid) >= MAX_TASKS);
    assign w_sum  = {1'b0, r_in.now_seconds} + {1'b0, r_in.sleep_seconds};

    assign o_busy = (r_fsm != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_size  <= CW'(1);
            r_run   <= '0;
            r_count <= CW'(1);
            o_valid <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_state[k] <= (k == 0) ? ST_RUNNING : ST_DEAD;
                r_wake[k]  <= '0;
                r_pages[k] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_start) begin
                        r_in     <= i_in;
                        r_idx    <= '0;
                        r_newpid <= '0;
                        r_sw     <= 1'b0;
                        r_found  <= 1'b0;
                        unique case (i_in.op)
                            OP_CREATE: begin
                                r_status <= STS_OK;
                                r_fsm    <= S_CSCAN;
                            end
                            OP_SCHEDULE: begin
                                r_status <= STS_OK;
                                r_demote <= i_in.save_old;
                                r_fsm    <= S_SWEEP;
                            end
                            OP_KILL, OP_SLEEP: begin
                                r_status <= STS_OK;
                                r_fsm    <= S_FINISH;
                            end
                            OP_EXIT: begin
                                if (r_run == '0) begin
                                    r_status <= STS_REFUSED;
                                    r_fsm    <= S_DONE;
                                end else begin
                                    r_status <= STS_OK;
                                    r_state[r_run] <= ST_TOFREE;
                                    if (r_count > CW'(1)) r_count <= r_count - 1'b1;
                                    r_demote <= 1'b1;
                                    r_fsm    <= S_SWEEP;
                                end
                            end
                            OP_RESET: begin
                                for (int k = 1; k < MAX_TASKS; k++)
                                    if (CW'(k) < r_size) r_state[k] <= ST_TOFREE;
                                r_status <= STS_OK;
                                r_count  <= CW'(1);
                                r_demote <= 1'b0;
                                r_fsm    <= S_SWEEP;
                            end
                            default: begin
                                r_status <= STS_REFUSED;
                                r_fsm    <= S_DONE;
                            end
                        endcase
                    end
                end
                // kill / sleep checks, done in the cycle after capture
                S_FINISH: begin
                    if (w_tgt_bad) begin
                        r_status <= STS_REFUSED;
                        r_fsm    <= S_DONE;
                    end else if (r_in.op == OP_KILL) begin
                        if (r_state[r_in.target_pid[IW-1:0]] != ST_DEAD &&
                            r_state[r_in.target_pid[IW-1:0]] != ST_TOFREE) begin
                            r_state[r_in.target_pid[IW-1:0]] <= ST_TOFREE;
                            if (r_count > CW'(1)) r_count <= r_count - 1'b1;
                            if (r_in.target_pid[IW-1:0] == r_run) begin
                                r_demote <= 1'b0;
                                r_fsm    <= S_SWEEP;
                            end else begin
                                r_fsm <= S_DONE;
                            end
                        end else begin
                            r_fsm <= S_DONE;
                        end
                    end else begin
                        r_state[r_in.target_pid[IW-1:0]] <= ST_SLEEPING;
                        r_wake[r_in.target_pid[IW-1:0]]  <= w_sum[32] ? '1 : w_sum[31:0];
                        r_demote <= 1'b1;
                        r_fsm    <= S_SWEEP;
                    end
                end
                // create: reuse the lowest dead or to-free slot, else append a new slot
                S_CSCAN: begin
                    if (r_idx < r_size) begin
                        if (w_st == ST_TOFREE || w_st == ST_DEAD) begin
                            r_state[w_ptr] <= ST_READY;
                            r_pages[w_ptr] <= r_in.stack_pages;
                            r_newpid       <= 4'(w_ptr);
                            if (r_count < CW'(MAX_TASKS)) r_count <= r_count + 1'b1;
                            r_fsm <= S_DONE;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_fsm <= S_DONE;
                        if (r_size >= CW'(MAX_TASKS)) begin
                            r_status <= STS_FULL;
                        end else begin
                            r_state[r_size[IW-1:0]] <= ST_READY;
                            r_pages[r_size[IW-1:0]] <= r_in.stack_pages;
                            r_newpid <= 4'(r_size);
                            r_size   <= r_size + 1'b1;
                            if (r_count < CW'(MAX_TASKS)) r_count <= r_count + 1'b1;
                        end
                    end
                end
                // pass part 1: wake sleepers, free to-free slots
                S_SWEEP: begin
                    if (r_idx < r_size) begin
                        if (w_st == ST_SLEEPING && w_wake) r_state[w_ptr] <= ST_READY;
                        else if (w_st == ST_TOFREE) r_state[w_ptr] <= ST_DEAD;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx    <= '0;
                        r_cand   <= r_run;
                        r_chosen <= '0;
                        r_found  <= 1'b0;
                        r_fsm    <= S_SEARCH;
                    end
                end
                // pass part 2: round-robin search after the running slot
                S_SEARCH: begin
                    if (r_idx < r_size && !r_found) begin
                        r_cand <= w_next;
                        if (r_state[w_next] == ST_READY || r_state[w_next] == ST_RUNNING) begin
                            r_chosen <= w_next;
                            r_found  <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        if (r_demote && r_state[r_run] == ST_RUNNING && r_chosen != r_run)
                            r_state[r_run] <= ST_READY;
                        r_state[r_chosen] <= ST_RUNNING;
                        r_run <= r_chosen;
                        r_sw  <= 1'b1;
                        r_fsm <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_out.status             <= r_status;
                    o_out.new_pid            <= r_newpid;
                    o_out.active_pid         <= 4'(r_run);
                    o_out.switched           <= r_sw;
                    o_out.live_count         <= 5'(r_count);
                    o_out.active_stack_pages <= r_pages[r_run];
                    r_fsm <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

endmodule
